// ===== design/load_cell_balance_averager_macros.svh =====
// Assertion macros for the load cell balance averager.
// Included by the top level; needs nothing else.
`ifndef LOAD_CELL_BALANCE_AVERAGER_MACROS_SVH
`define LOAD_CELL_BALANCE_AVERAGER_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define LCBA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define LCBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lcba_pkg.sv =====
// Shared types and constants of the load cell balance averager.
// Depends on nothing; imported by every module of the block except the RAM.
`default_nettype none

package lcba_pkg;

   // Ratio format: signed Q1.13 (13 fraction bits in 15), magnitudes never above one.
   localparam int RATIO_W    = 15;
   localparam int FRAC_SHIFT = 13;
   localparam int RATIO_MAX  = 1 << FRAC_SHIFT;
   // Quotient bits of every division: magnitudes reach RATIO_MAX itself.
   localparam int QUO_W      = FRAC_SHIFT + 1;

   // Output field widths.
   localparam int TOTAL_W = 18;
   localparam int PAIR_W  = 17;

   // Sequencer states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RATIO = 3'b010,
      ST_AVG   = 3'b100
   } state_type;

   // Commands from the sequencer to each axis.
   typedef struct packed {
      logic load;    // new item: read the oldest entry, start the ratio division
      logic commit;  // ratio done: update history and sum, start the average division
   } axis_ctrl_type;

endpackage

`default_nettype wire

// ===== design/lcba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module lcba_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 10,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/lcba_div.sv =====
// Restoring divider, one quotient bit per cycle, QUO_W bits per division.
// Depends on lcba_pkg. The dividend must be below the divisor times 2**QUO_W.
`default_nettype none

module lcba_div #(
   parameter int DVD_W = 30,
   parameter int DVS_W = 18
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [DVD_W-1:0]           dividend,
   input  wire logic [DVS_W-1:0]           divisor,
   output logic                            busy,
   output logic [lcba_pkg::QUO_W-1:0]      quotient
);
   import lcba_pkg::*;

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DVS_W:0]   trial;
   logic             fits;

   // One step: shift the next dividend bit into the remainder and try a subtract.
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         // The high dividend bits are already below the divisor.
         rem_in  = DVS_W'(dividend >> QUO_W);
         quo_in  = dividend[QUO_W-1:0];
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : DVS_W'(trial);
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== design/lcba_axis.sv =====
// One balance axis: ratio division, history RAM, running sum and average division.
// Depends on lcba_pkg, lcba_div and lcba_ram.
`default_nettype none

module lcba_axis #(
   parameter int WINDOW      = 10,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lcba_pkg::axis_ctrl_type            ctrl,
   input  wire logic                               ratio_neg,
   input  wire logic [SAMPLE_BITS+lcba_pkg::QUO_W-1:0] ratio_dividend,
   input  wire logic [SAMPLE_BITS+1:0]             total,
   input  wire logic                               zero,
   output logic                                    busy,
   output logic signed [lcba_pkg::RATIO_W-1:0]     ratio_avg
);
   import lcba_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int MAG_W  = $clog2(RATIO_MAX * WINDOW + 1);
   localparam int SUM_W  = MAG_W + 1;
   localparam int RDVD_W = SAMPLE_BITS + QUO_W;
   localparam int TOT_W  = SAMPLE_BITS + 2;
   localparam int DVD_W  = (RDVD_W > MAG_W) ? RDVD_W : MAG_W;
   localparam int DVS_W  = (TOT_W > FILL_W) ? TOT_W : FILL_W;

   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [SUM_W:0]     sum_wide;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic                      neg_ff;
   logic                      full;
   logic [RATIO_W-1:0]        old_entry;
   logic [QUO_W-1:0]          quo;
   logic signed [RATIO_W-1:0] quo_ext;
   logic signed [RATIO_W-1:0] ratio;
   logic [MAG_W-1:0]          sum_mag;
   logic                      div_start;
   logic [DVD_W-1:0]          div_dividend;
   logic [DVS_W-1:0]          div_divisor;

   // History of ratios, read at the write slot when an item arrives.
   lcba_ram #(
      .WIDTH(RATIO_W),
      .DEPTH(WINDOW)
   ) u_hist (
      .clock  (clock),
      .wr_en  (ctrl.commit),
      .wr_addr(slot_ff),
      .wr_data(ratio),
      .rd_en  (ctrl.load),
      .rd_addr(slot_ff),
      .rd_data(old_entry)
   );

   // Signed quotient of whichever division last ran.
   assign quo_ext = RATIO_W'({1'b0, quo});
   assign ratio   = zero ? '0 : (neg_ff ? -quo_ext : quo_ext);

   // Running sum: drop the oldest entry once the window is full, add the new ratio.
   assign full     = (fill_ff == FILL_W'(WINDOW));
   assign sum_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(ratio)
                   - (full ? (SUM_W+1)'($signed(old_entry)) : '0);
   assign sum_in   = SUM_W'(sum_wide);
   assign fill_in  = full ? fill_ff : fill_ff + 1'b1;
   assign slot_in  = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
   assign sum_mag  = MAG_W'(sum_in[SUM_W-1] ? -sum_in : sum_in);

   // The divider serves the ratio first and the average second.
   assign div_start    = ctrl.load | ctrl.commit;
   assign div_dividend = ctrl.load ? DVD_W'(ratio_dividend) : DVD_W'(sum_mag);
   assign div_divisor  = ctrl.load ? DVS_W'(total) : DVS_W'(fill_in);

   lcba_div #(
      .DVD_W(DVD_W),
      .DVS_W(DVS_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .busy    (busy),
      .quotient(quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         fill_ff <= '0;
         slot_ff <= '0;
      end else if (ctrl.commit) begin
         sum_ff  <= sum_in;
         fill_ff <= fill_in;
         slot_ff <= slot_in;
      end
   end

   // Sign of the running division: ratio sign first, then the sum sign.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         neg_ff <= ratio_neg;
      end else if (ctrl.commit) begin
         neg_ff <= sum_in[SUM_W-1];
      end
   end

   assign ratio_avg = neg_ff ? -quo_ext : quo_ext;

endmodule

`default_nettype wire

// ===== design/load_cell_balance_averager.sv =====
// Load cell balance averager: four cell readings in, sums and smoothed balance out.
// Handshake on both channels: an item moves at a clock edge with valid high and
// stall low. One request item gives exactly one response item.
// Each item forms the total, right pair (cells 0+1) and left pair (cells 2+3)
// sums and two balance ratios in signed Q1.13, each truncated toward zero. The X
// ratio is averaged over X_WINDOW items and the Y ratio over Y_WINDOW items,
// dividing by the items seen so far until the window is full. A zero total
// gives ratios of zero and sets zero_total.
// A new item is taken only once the previous one has left the sequencer: the X
// and Y axes each run one divider twice, once for the ratio and once for the
// average, reading the history RAM as the ratio division starts and writing
// it as the average division starts. req_stall is high while an item is at work.
// A finished item waits in the output register while rsp_stall is high; the
// next item may already be accepted, and its result waits until the register
// is taken. Synchronous reset clears the sums, fill counts and ring slots.
`default_nettype none
`include "load_cell_balance_averager_macros.svh"

module load_cell_balance_averager #(
   parameter int X_WINDOW    = 10,
   parameter int Y_WINDOW    = 5,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [SAMPLE_BITS-1:0]                req_cell0_weight,
   input  wire logic [SAMPLE_BITS-1:0]                req_cell1_weight,
   input  wire logic [SAMPLE_BITS-1:0]                req_cell2_weight,
   input  wire logic [SAMPLE_BITS-1:0]                req_cell3_weight,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [lcba_pkg::TOTAL_W-1:0]               rsp_total_weight,
   output logic [lcba_pkg::PAIR_W-1:0]                rsp_right_weight,
   output logic [lcba_pkg::PAIR_W-1:0]                rsp_left_weight,
   output logic signed [lcba_pkg::RATIO_W-1:0]        rsp_x_ratio_avg,
   output logic signed [lcba_pkg::RATIO_W-1:0]        rsp_y_ratio_avg,
   output logic                                       rsp_zero_total
);
   import lcba_pkg::*;

   localparam int TOT_W  = SAMPLE_BITS + 2;
   localparam int MAGN_W = SAMPLE_BITS + 1;
   localparam int RDVD_W = SAMPLE_BITS + QUO_W;

   state_type                 state_ff, state_in;
   logic                      req_accept;
   logic                      rsp_free;
   logic                      rsp_load;
   logic                      rsp_valid_ff;
   axis_ctrl_type             ctrl;
   logic                      x_busy, y_busy;
   logic signed [RATIO_W-1:0] x_avg, y_avg;

   logic [TOT_W-1:0]          c0, c1, c2, c3;
   logic [TOT_W-1:0]          total, right_sum, left_sum;
   logic signed [TOT_W-1:0]   x_num, y_num;
   logic [MAGN_W-1:0]         x_mag, y_mag;
   logic [RDVD_W-1:0]         x_dvd, y_dvd;

   logic [TOT_W-1:0]          total_ff, right_ff, left_ff;
   logic                      zero_ff;

   assign req_accept = req_valid & ~req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_free   = ~rsp_valid_ff | ~rsp_stall;

   // Cell sums and balance numerators straight from the incoming item.
   assign c0        = TOT_W'(req_cell0_weight);
   assign c1        = TOT_W'(req_cell1_weight);
   assign c2        = TOT_W'(req_cell2_weight);
   assign c3        = TOT_W'(req_cell3_weight);
   assign right_sum = c0 + c1;
   assign left_sum  = c2 + c3;
   assign total     = right_sum + left_sum;
   assign x_num     = $signed(c2 + c0) - $signed(c1 + c3);
   assign y_num     = $signed(left_sum) - $signed(right_sum);
   assign x_mag     = MAGN_W'(x_num[TOT_W-1] ? -x_num : x_num);
   assign y_mag     = MAGN_W'(y_num[TOT_W-1] ? -y_num : y_num);
   assign x_dvd     = {x_mag, {FRAC_SHIFT{1'b0}}};
   assign y_dvd     = {y_mag, {FRAC_SHIFT{1'b0}}};

   // Sequencer: ratio divisions, then history update and average divisions.
   always_comb begin
      state_in    = state_ff;
      ctrl.load   = 1'b0;
      ctrl.commit = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ctrl.load = 1'b1;
               state_in  = ST_RATIO;
            end
         end
         ST_RATIO: begin
            if (!x_busy && !y_busy) begin
               ctrl.commit = 1'b1;
               state_in    = ST_AVG;
            end
         end
         ST_AVG: begin
            if (!x_busy && !y_busy && rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sums of the item at work.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         total_ff <= total;
         right_ff <= right_sum;
         left_ff  <= left_sum;
         zero_ff  <= (total == '0);
      end
   end

   lcba_axis #(
      .WINDOW     (X_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_x_axis (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .ratio_neg     (x_num[TOT_W-1]),
      .ratio_dividend(x_dvd),
      .total         (total),
      .zero          (zero_ff),
      .busy          (x_busy),
      .ratio_avg     (x_avg)
   );

   lcba_axis #(
      .WINDOW     (Y_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_y_axis (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .ratio_neg     (y_num[TOT_W-1]),
      .ratio_dividend(y_dvd),
      .total         (total),
      .zero          (zero_ff),
      .busy          (y_busy),
      .ratio_avg     (y_avg)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_total_weight <= TOTAL_W'(total_ff);
         rsp_right_weight <= PAIR_W'(right_ff);
         rsp_left_weight  <= PAIR_W'(left_ff);
         rsp_x_ratio_avg  <= x_avg;
         rsp_y_ratio_avg  <= y_avg;
         rsp_zero_total   <= zero_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Checks on the sequencer and the two axes.
   `LCBA_ASSERT_NEXT(a_accept_starts, clock, reset, req_accept, state_ff == ST_RATIO, "accepted item did not start the ratio divisions")
   `LCBA_ASSERT_ALWAYS(a_axes_lockstep, clock, reset, x_busy == y_busy, "X and Y dividers out of step")
   `LCBA_ASSERT_ALWAYS(a_idle_not_busy, clock, reset, !(state_ff == ST_IDLE && x_busy), "divider busy while idle")
   `LCBA_ASSERT_NEXT(a_load_valid, clock, reset, rsp_load, rsp_valid_ff, "loaded result not shown as valid")

endmodule

`default_nettype wire
